// File: hw/rtl/dht_pkg.sv
package dht_pkg;

    localparam int TABLE_SIZE_DEF = 1021;

    localparam int OP_W      = 2;
    localparam int HASH_W    = 64;
    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 10;

    // The hash is reduced a chunk of bits per cycle, most significant first.
    localparam int CHUNK_W     = 8;
    localparam int CHUNKS      = HASH_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_NEW   = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_OCC   = 2'd0,
        MARK_EMPTY = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef struct packed {
        mark_t               mark;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } bucket_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FIRST,
        S_CHECK,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic req_ready;
        logic cap;
        logic mod_step;
        logic probe_first;
        logic probe_next;
        logic check;
        logic commit;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic mod_done;
        logic clr_done;
        logic stop;
        logic out_busy;
    } sts_t;

endpackage

// File: hw/rtl/dht_if.sv
interface dht_req_if;
    import dht_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [HASH_W-1:0]   key_hash;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    modport source (output valid, operation, key_hash, key, value, input ready);
    modport sink (input valid, operation, key_hash, key, value, output ready);
endinterface

interface dht_rsp_if;
    import dht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [KEY_W-1:0]     stored_key;
    logic [VALUE_W-1:0]   stored_value;
    logic [OUT_CNT_W-1:0] live_entries;
    modport source (output valid, status, slot_index, stored_key, stored_value,
                    live_entries, input ready);
    modport sink (input valid, status, slot_index, stored_key, stored_value,
                  live_entries, output ready);
endinterface

// File: hw/rtl/double_hash_table_tombstones_core.sv
// Open-addressing key/value table with double hashing and tombstones. After
// reset the block sweeps all TABLE_SIZE buckets to empty, one per cycle, and
// accepts no request until the sweep is done. A transaction then reduces the
// 64-bit hash 8 bits per cycle into start and step, reads the first bucket,
// probes buckets one after another on the single read port of the bucket
// memory, and commits once the output register is free. One request is
// worked on at a time; the result sits in an output register so the next
// request is taken while it waits. Slot and live-entry outputs carry the low
// 10 bits of the internal values.
module double_hash_table_tombstones_core #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dht_req_if.sink    req,
    dht_rsp_if.source  rsp
);
    import dht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    dht_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// File: hw/rtl/dht_ram.sv
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dht_mod.sv
module dht_mod #(
    parameter int MODULUS = 1021,
    parameter int RW      = 10
) (
    input  logic                        clk,
    input  logic                        clear,
    input  logic                        en,
    input  logic [dht_pkg::CHUNK_W-1:0] chunk,
    output logic [RW-1:0]               rem
);
    import dht_pkg::*;

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;

    // Restoring reduction: each bit doubles the remainder, adds the bit and subtracts the modulus at most once.
    always_comb
    begin
        logic [RW:0] w;
        rem_next = rem_reg;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            w = {rem_next, chunk[CHUNK_W-1-i]};
            if (w >= (RW+1)'(MODULUS))
            begin
                w = w - (RW+1)'(MODULUS);
            end
            rem_next = w[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            rem_reg <= '0;
        end
        else if (en)
        begin
            rem_reg <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule

// File: hw/rtl/dht_ctrl.sv
module dht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  dht_pkg::sts_t sts,
    output dht_pkg::cmd_t cmd
);
    import dht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.stop)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.req_ready = 1'b1;
                cmd.cap       = sts.req_valid;
            end
            S_HASH:
            begin
                cmd.mod_step = 1'b1;
            end
            S_FIRST:
            begin
                cmd.probe_first = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check      = 1'b1;
                cmd.probe_next = !sts.stop;
            end
            S_COMMIT:
            begin
                cmd.commit = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/dht_dp.sv
module dht_dp #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dht_pkg::cmd_t   cmd,
    output dht_pkg::sts_t   sts,
    dht_req_if.sink         req,
    dht_rsp_if.source       rsp
);
    import dht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int LW = $clog2(TABLE_SIZE + 1);
    localparam int BW = $bits(bucket_t);

    logic [OP_W-1:0]        op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic [CHUNK_CNT_W-1:0] chunk_cnt_reg;
    logic [IW-1:0]          start;
    logic [IW-1:0]          rem_m1;
    logic [IW-1:0]          step;
    logic [IW-1:0]          at_reg;
    logic [IW-1:0]          tomb_reg;
    logic                   tomb_seen_reg;
    logic [IW-1:0]          clr_cnt_reg;
    logic [LW-1:0]          live_reg;
    logic [LW-1:0]          live_next;

    logic [IW:0]            sum;
    logic [IW-1:0]          at_adv;
    logic [BW-1:0]          rdata;
    bucket_t                rd_b;
    logic                   hit_match;
    logic                   hit_empty;

    logic                   re;
    logic [IW-1:0]          raddr;
    logic                   we;
    logic [IW-1:0]          waddr;
    bucket_t                wdata;

    logic                   we_c;
    logic [IW-1:0]          waddr_c;
    bucket_t                wdata_c;
    status_t                status_c;
    logic [IW-1:0]          slot_c;
    logic [KEY_W-1:0]       skey_c;
    logic [VALUE_W-1:0]     sval_c;

    logic                   rsp_valid_reg;
    status_t                out_status_reg;
    logic [OUT_IDX_W-1:0]   out_slot_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [VALUE_W-1:0]     out_value_reg;
    logic [OUT_CNT_W-1:0]   out_live_reg;

    dht_mod #(.MODULUS(TABLE_SIZE), .RW(IW)) u_mod_start (
        .clk   (clk),
        .clear (cmd.cap),
        .en    (cmd.mod_step),
        .chunk (hash_reg[HASH_W-1 -: CHUNK_W]),
        .rem   (start)
    );

    dht_mod #(.MODULUS(TABLE_SIZE - 1), .RW(IW)) u_mod_step (
        .clk   (clk),
        .clear (cmd.cap),
        .en    (cmd.mod_step),
        .chunk (hash_reg[HASH_W-1 -: CHUNK_W]),
        .rem   (rem_m1)
    );

    dht_ram #(.WIDTH(BW), .DEPTH(TABLE_SIZE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign step = rem_m1 + IW'(1);
    assign sum  = {1'b0, at_reg} + {1'b0, step};
    assign at_adv = (sum >= (IW+1)'(TABLE_SIZE)) ? IW'(sum - (IW+1)'(TABLE_SIZE)) : sum[IW-1:0];

    assign rd_b      = bucket_t'(rdata);
    assign hit_match = (rd_b.mark == MARK_OCC) && (rd_b.key == key_reg);
    assign hit_empty = (rd_b.mark == MARK_EMPTY);

    assign re    = cmd.probe_first || cmd.probe_next;
    assign raddr = cmd.probe_first ? start : at_adv;

    assign sts.req_valid = req.valid;
    assign sts.mod_done  = (chunk_cnt_reg == CHUNK_CNT_W'(CHUNKS - 1));
    assign sts.clr_done  = (clr_cnt_reg == IW'(TABLE_SIZE - 1));
    assign sts.stop      = hit_match || hit_empty || (at_adv == start);
    assign sts.out_busy  = rsp_valid_reg && !rsp.ready;
    assign req.ready     = cmd.req_ready;

    // Outcome of a finished probe; the read data still holds the last bucket.
    always_comb
    begin
        we_c      = 1'b0;
        waddr_c   = at_reg;
        wdata_c   = rd_b;
        status_c  = STAT_MISS;
        slot_c    = '0;
        skey_c    = '0;
        sval_c    = '0;
        live_next = live_reg;
        case (op_t'(op_reg))
            OP_LOOKUP:
            begin
                if (hit_match)
                begin
                    status_c = STAT_FOUND;
                    slot_c   = at_reg;
                    skey_c   = rd_b.key;
                    sval_c   = rd_b.value;
                end
            end
            OP_INSERT:
            begin
                if (hit_match)
                begin
                    we_c          = 1'b1;
                    wdata_c.value = value_reg;
                    status_c      = STAT_FOUND;
                    slot_c        = at_reg;
                end
                else if (tomb_seen_reg || hit_empty)
                begin
                    we_c      = 1'b1;
                    waddr_c   = tomb_seen_reg ? tomb_reg : at_reg;
                    wdata_c   = '{mark: MARK_OCC, key: key_reg, value: value_reg};
                    live_next = live_reg + LW'(1);
                    status_c  = STAT_NEW;
                    slot_c    = waddr_c;
                end
                else
                begin
                    status_c = STAT_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_match)
                begin
                    we_c         = 1'b1;
                    wdata_c.mark = MARK_TOMB;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - LW'(1);
                    end
                    status_c = STAT_FOUND;
                    slot_c   = at_reg;
                end
            end
            default:
            begin
                status_c = STAT_MISS;
            end
        endcase
    end

    assign we    = cmd.clr_step || (cmd.commit && we_c);
    assign waddr = cmd.clr_step ? clr_cnt_reg : waddr_c;
    assign wdata = cmd.clr_step ? bucket_t'{mark: MARK_EMPTY, key: '0, value: '0} : wdata_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            chunk_cnt_reg <= '0;
            tomb_seen_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.cap)
            begin
                chunk_cnt_reg <= '0;
                tomb_seen_reg <= 1'b0;
            end
            else
            begin
                if (cmd.mod_step)
                begin
                    chunk_cnt_reg <= chunk_cnt_reg + CHUNK_CNT_W'(1);
                end
                if (cmd.check && (rd_b.mark == MARK_TOMB))
                begin
                    tomb_seen_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                live_reg      <= live_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg    <= req.operation;
            key_reg   <= req.key;
            value_reg <= req.value;
            hash_reg  <= req.key_hash;
        end
        else if (cmd.mod_step)
        begin
            hash_reg <= hash_reg << CHUNK_W;
        end
        if (cmd.probe_first || cmd.probe_next)
        begin
            at_reg <= raddr;
        end
        if (cmd.check && (rd_b.mark == MARK_TOMB))
        begin
            tomb_reg <= at_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg <= status_c;
            out_slot_reg   <= OUT_IDX_W'(slot_c);
            out_key_reg    <= skey_c;
            out_value_reg  <= sval_c;
            out_live_reg   <= OUT_CNT_W'(live_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot_index   = out_slot_reg;
    assign rsp.stored_key   = out_key_reg;
    assign rsp.stored_value = out_value_reg;
    assign rsp.live_entries = out_live_reg;

endmodule

// File: hw/rtl/dht_chk.sv
module dht_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [dht_pkg::STATUS_W-1:0]  status,
    input logic [dht_pkg::OUT_IDX_W-1:0] slot_index,
    input logic [dht_pkg::KEY_W-1:0]     stored_key,
    input logic [dht_pkg::VALUE_W-1:0]   stored_value
);
    import dht_pkg::*;

    // A stalled result keeps its status and slot index.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot_index))
        else $error("response changed while stalled");

    // After taking a request the block works on it before taking another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted in consecutive cycles");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_MISS || status == STAT_FULL) |-> slot_index == '0)
        else $error("nonzero slot on miss or full");

    a_key_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_FOUND |-> stored_key == '0 && stored_value == '0)
        else $error("stored key or value on a result that found nothing");

endmodule

bind double_hash_table_tombstones_core dht_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .slot_index   (rsp.slot_index),
    .stored_key   (rsp.stored_key),
    .stored_value (rsp.stored_value)
);
